// ===== hw/rtl/iufs_pkg.sv =====
// ---------------------------------------------------------------------------
// iufs_pkg: shared types and constants of the isothermal upwind flow step
// Holds the fixed-point format, the payload structs, the register indexes
// and the result type of the velocity divider.
// ---------------------------------------------------------------------------
package iufs_pkg;

    // Fixed-point format and grid size default.
    localparam int FRAC_BITS     = 16;
    localparam int MAX_CELLS_DEF = 4096;
    localparam int IDX_W         = 12;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] REG_FLUX_GAIN     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_GAIN = 1'd1;
    localparam logic [CFG_DATA_W-1:0] FLUX_GAIN_RST     = 17'd32768;
    localparam logic [CFG_DATA_W-1:0] PRESSURE_GAIN_RST = 17'd16384;

    // One input cell.
    typedef struct packed {
        logic [30:0]        in_density;
        logic signed [31:0] in_momentum;
        logic               in_last_cell;
    } in_item_t;

    // One emitted cell.
    typedef struct packed {
        logic [30:0]        out_density;
        logic signed [31:0] out_momentum;
        logic [IDX_W-1:0]   cell_index;
        logic               out_last_cell;
        logic               density_error;
    } out_item_t;

    // Result of one velocity division.
    typedef struct packed {
        logic               done;
        logic signed [31:0] vel;
        logic signed [31:0] vel_ghost;
    } div_res_t;

endpackage

// ===== hw/rtl/iufs_div.sv =====
// ---------------------------------------------------------------------------
// iufs_div: radix-2 velocity divider
// Computes momentum * 2^FRAC_BITS / density, truncated toward zero, one
// quotient bit per cycle, and returns the saturated velocity of the cell
// and of its mirrored ghost (negated momentum).
// ---------------------------------------------------------------------------
module iufs_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [30:0]             density,
    input  logic signed [31:0]      momentum,
    output iufs_pkg::div_res_t      res
);
    import iufs_pkg::*;

    localparam int DVW = 32 + FRAC_BITS;
    localparam int CNW = $clog2(DVW);
    localparam logic [CNW-1:0] LAST_STEP = CNW'(DVW - 1);

    logic           busy_reg;
    logic           fin_reg;
    logic [CNW-1:0] cnt_reg;
    logic [DVW-1:0] quo_reg;
    logic [31:0]    rem_reg;
    logic [30:0]    dvs_reg;
    logic           neg_reg;
    logic           zero_reg;

    logic [31:0]    mag;
    logic [31:0]    trial;
    logic           ge;

    // Saturate the unsigned quotient magnitude with the given sign.
    function automatic logic signed [31:0] sat_quot(input logic [DVW-1:0] q,
                                                   input logic neg);
        logic signed [31:0] r;
        if (!neg)
        begin
            if (|q[DVW-1:31])
                r = 32'sh7FFFFFFF;
            else
                r = $signed(q[31:0]);
        end
        else
        begin
            if (|q[DVW-1:32] || (q[31] && |q[30:0]))
                r = 32'sh80000000;
            else
                r = $signed(-q[31:0]);
        end
        return r;
    endfunction

    // Magnitude of the momentum and one restoring step.
    always_comb
    begin
        mag   = momentum[31] ? (~$unsigned(momentum) + 32'd1) : $unsigned(momentum);
        trial = {rem_reg[30:0], quo_reg[DVW-1]};
        ge    = trial >= {1'b0, dvs_reg};
    end

    // Iteration control and shift registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= {mag, {FRAC_BITS{1'b0}}};
                rem_reg  <= '0;
                dvs_reg  <= density;
                neg_reg  <= momentum[31];
                zero_reg <= (density == 31'd0);
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? (trial - {1'b0, dvs_reg}) : trial;
                quo_reg <= {quo_reg[DVW-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    // A zero density gives zero velocity.
    always_comb
    begin
        res.done      = fin_reg;
        res.vel       = zero_reg ? 32'sd0 : sat_quot(quo_reg, neg_reg);
        res.vel_ghost = zero_reg ? 32'sd0 : sat_quot(quo_reg, !neg_reg);
    end

endmodule

// ===== hw/rtl/isothermal_upwind_flow_step.sv =====
// ---------------------------------------------------------------------------
// isothermal_upwind_flow_step: streaming 1D isothermal donor-cell step
// Each accepted cell passes through the radix-2 velocity divider, then
// through the half-step updates and the emitted cells, which share one
// 33x33 multiplier; skipped jobs are passed over. A new cell is taken only
// after the last one is through all its jobs, and output stalls hold it.
// In_ready is high only while the sequencer idles.
// Reset clears all windows and the cell count and loads the default gains.
// ---------------------------------------------------------------------------
module isothermal_upwind_flow_step #(
    parameter int MAX_CELLS = iufs_pkg::MAX_CELLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  iufs_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output iufs_pkg::out_item_t                 out_data,
    input  logic                                cfg_write_en,
    input  logic [iufs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iufs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import iufs_pkg::*;

    localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] LAST_POS = CW'(MAX_CELLS - 1);

    localparam logic [2:0] JOB_HS_A    = 3'd0;
    localparam logic [2:0] JOB_EM_MID  = 3'd1;
    localparam logic [2:0] JOB_HS_B    = 3'd2;
    localparam logic [2:0] JOB_EM_PREV = 3'd3;
    localparam logic [2:0] JOB_EM_LAST = 3'd4;
    localparam logic [2:0] JOB_DONE    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DISPATCH,
        ST_HS_MUL,
        ST_HS_ACC,
        ST_EM_MUL,
        ST_EM_OUT
    } state_t;

    typedef struct packed {
        logic [30:0]        d;
        logic signed [32:0] m;
        logic signed [31:0] v;
    } triple_t;

    state_t                 state_reg;
    logic [2:0]             job_reg;
    logic [2:0]             step_reg;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          k_reg;
    logic                   last_reg;
    logic [16:0]            fg_reg;
    logic [16:0]            pg_reg;
    logic [30:0]            dw_reg [3];
    logic signed [31:0]     mw_reg [3];
    logic signed [31:0]     vw_reg [3];
    logic signed [31:0]     vgw_reg [3];
    logic [30:0]            hdw_reg [3];
    logic signed [31:0]     hmw_reg [3];
    logic                   hew_reg [3];
    logic signed [31:0]     fdp_reg;
    logic signed [31:0]     fmp_reg;
    logic signed [31:0]     fdn_reg;
    logic signed [31:0]     fmn_reg;
    logic [30:0]            hd_tmp_reg;
    logic signed [65:0]     prod_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    div_res_t               div_res;
    logic                   div_start;
    logic                   out_load;

    logic [XW-1:0]          kx;
    logic                   k0, k1, k2, k_ge1, k_ge2;
    logic                   job_en;
    logic                   hs_b;
    triple_t                s0, s1, s2, g1, g2;
    triple_t                tl, tc, tr, sp, sn;
    logic signed [32:0]     up_sum, un_sum;
    logic signed [31:0]     up, un;
    logic                   up_pos, un_pos;
    logic signed [32:0]     mul_a, mul_b;
    logic signed [66:0]     sh67;
    logic signed [31:0]     fsat;
    logic [30:0]            hd_calc;
    logic signed [31:0]     hm_calc;
    logic signed [31:0]     em_calc;
    logic                   err_calc;
    logic [1:0]             em_ls, em_cs, em_rs;
    logic [XW-1:0]          em_idx;
    logic                   em_last;

    // Saturate to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [66:0] x);
        logic signed [31:0] r;
        if (!x[66] && |x[65:31])
            r = 32'sh7FFFFFFF;
        else if (x[66] && !(&x[65:31]))
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    // Saturate to 0 .. 2^31-1.
    function automatic logic [30:0] satpos31(input logic signed [66:0] x);
        logic [30:0] r;
        if (x[66])
            r = 31'd0;
        else if (|x[65:31])
            r = 31'h7FFFFFFF;
        else
            r = x[30:0];
        return r;
    endfunction

    assign div_start = (state_reg == ST_IDLE) && in_valid;

    // An emitted cell is loaded when the output register is free or leaving.
    assign out_load = (state_reg == ST_EM_OUT) && (!out_valid_reg || out_ready);

    iufs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .density  (in_data.in_density),
        .momentum (in_data.in_momentum),
        .res      (div_res)
    );

    // Position flags of the current cell.
    always_comb
    begin
        kx    = XW'(k_reg);
        k0    = (kx == XW'(0));
        k1    = (kx == XW'(1));
        k2    = (kx == XW'(2));
        k_ge1 = !k0;
        k_ge2 = !k0 && !k1;
        case (job_reg)
            JOB_HS_A:    job_en = k_ge1;
            JOB_EM_MID:  job_en = k_ge2;
            JOB_HS_B:    job_en = last_reg;
            JOB_EM_PREV: job_en = last_reg && k_ge1;
            JOB_EM_LAST: job_en = last_reg;
            default:     job_en = 1'b0;
        endcase
        hs_b = (job_reg == JOB_HS_B);
    end

    // Neighbour triples, with reflective ghosts at the walls.
    always_comb
    begin
        s0 = '{d: dw_reg[0], m: {mw_reg[0][31], mw_reg[0]}, v: vw_reg[0]};
        s1 = '{d: dw_reg[1], m: {mw_reg[1][31], mw_reg[1]}, v: vw_reg[1]};
        s2 = '{d: dw_reg[2], m: {mw_reg[2][31], mw_reg[2]}, v: vw_reg[2]};
        g1 = '{d: dw_reg[1], m: -{mw_reg[1][31], mw_reg[1]}, v: vgw_reg[1]};
        g2 = '{d: dw_reg[2], m: -{mw_reg[2][31], mw_reg[2]}, v: vgw_reg[2]};
        if (hs_b)
        begin
            tl = k0 ? g2 : s1;
            tc = s2;
            tr = g2;
        end
        else
        begin
            tl = k1 ? g1 : s0;
            tc = s1;
            tr = s2;
        end
        up_sum = {tc.v[31], tc.v} + {tr.v[31], tr.v};
        un_sum = {tl.v[31], tl.v} + {tc.v[31], tc.v};
        up     = up_sum[32:1];
        un     = un_sum[32:1];
        up_pos = !up[31] && (up != 32'sd0);
        un_pos = !un[31] && (un != 32'sd0);
        sp     = up_pos ? tc : tr;
        sn     = un_pos ? tl : tc;
        err_calc = (tl.d == 31'd0) || (tc.d == 31'd0) || (tr.d == 31'd0);
    end

    // Emit job selectors.
    always_comb
    begin
        em_ls   = 2'd0;
        em_cs   = 2'd1;
        em_rs   = 2'd2;
        em_idx  = kx;
        em_last = 1'b0;
        case (job_reg)
            JOB_EM_MID:
            begin
                em_ls  = k2 ? 2'd1 : 2'd0;
                em_idx = kx - XW'(2);
            end
            JOB_EM_PREV:
            begin
                em_ls  = k1 ? 2'd1 : 2'd0;
                em_idx = kx - XW'(1);
            end
            JOB_EM_LAST:
            begin
                em_ls   = k0 ? 2'd2 : 2'd1;
                em_cs   = 2'd2;
                em_last = 1'b1;
            end
            default:
            begin
                em_ls = 2'd0;
            end
        endcase
    end

    // Operand selection of the shared multiplier.
    always_comb
    begin
        mul_a = $signed({16'd0, pg_reg});
        mul_b = $signed({2'b00, hdw_reg[em_rs]}) - $signed({2'b00, hdw_reg[em_ls]});
        if (state_reg == ST_HS_MUL)
        begin
            case (step_reg)
                3'd0:
                begin
                    mul_a = $signed({2'b00, sp.d});
                    mul_b = {up[31], up};
                end
                3'd1:
                begin
                    mul_a = sp.m;
                    mul_b = {up[31], up};
                end
                3'd2:
                begin
                    mul_a = $signed({2'b00, sn.d});
                    mul_b = {un[31], un};
                end
                3'd3:
                begin
                    mul_a = sn.m;
                    mul_b = {un[31], un};
                end
                3'd4:
                begin
                    mul_a = $signed({16'd0, fg_reg});
                    mul_b = {fdp_reg[31], fdp_reg} - {fdn_reg[31], fdn_reg};
                end
                default:
                begin
                    mul_a = $signed({16'd0, fg_reg});
                    mul_b = {fmp_reg[31], fmp_reg} - {fmn_reg[31], fmn_reg};
                end
            endcase
        end
    end

    // Floored product and the values built from it.
    always_comb
    begin
        sh67    = {prod_reg[65], prod_reg >>> FRAC_BITS};
        fsat    = sat32(sh67);
        hd_calc = satpos31($signed({36'd0, tc.d}) - sh67);
        hm_calc = sat32({{34{tc.m[32]}}, tc.m} - sh67);
        em_calc = sat32({{35{hmw_reg[em_cs][31]}}, hmw_reg[em_cs]} - sh67);
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FLUX_GAIN_RST;
            pg_reg <= PRESSURE_GAIN_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_FLUX_GAIN:     fg_reg <= cfg_data;
                REG_PRESSURE_GAIN: pg_reg <= cfg_data;
                default:           fg_reg <= fg_reg;
            endcase
        end
    end

    // Sequencer, windows and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_HS_A;
            step_reg      <= 3'd0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                dw_reg[i]  <= '0;
                mw_reg[i]  <= '0;
                vw_reg[i]  <= '0;
                vgw_reg[i] <= '0;
                hdw_reg[i] <= '0;
                hmw_reg[i] <= '0;
                hew_reg[i] <= 1'b0;
            end
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        dw_reg[0] <= dw_reg[1];
                        dw_reg[1] <= dw_reg[2];
                        dw_reg[2] <= in_data.in_density;
                        mw_reg[0] <= mw_reg[1];
                        mw_reg[1] <= mw_reg[2];
                        mw_reg[2] <= in_data.in_momentum;
                        vw_reg[0] <= vw_reg[1];
                        vw_reg[1] <= vw_reg[2];
                        vgw_reg[0] <= vgw_reg[1];
                        vgw_reg[1] <= vgw_reg[2];
                        k_reg    <= cnt_reg;
                        job_reg  <= JOB_HS_A;
                        if (in_data.in_last_cell || cnt_reg >= LAST_POS)
                        begin
                            last_reg <= 1'b1;
                            cnt_reg  <= '0;
                        end
                        else
                        begin
                            last_reg <= 1'b0;
                            cnt_reg  <= cnt_reg + 1'b1;
                        end
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_res.done)
                    begin
                        vw_reg[2]  <= div_res.vel;
                        vgw_reg[2] <= div_res.vel_ghost;
                        state_reg  <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH:
                begin
                    step_reg <= 3'd0;
                    if (job_reg == JOB_DONE)
                        state_reg <= ST_IDLE;
                    else if (!job_en)
                        job_reg <= job_reg + 3'd1;
                    else if (job_reg == JOB_HS_A || job_reg == JOB_HS_B)
                        state_reg <= ST_HS_MUL;
                    else
                        state_reg <= ST_EM_MUL;
                end
                ST_HS_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_HS_ACC;
                end
                ST_HS_ACC:
                begin
                    step_reg  <= step_reg + 3'd1;
                    state_reg <= (step_reg >= 3'd5) ? ST_DISPATCH : ST_HS_MUL;
                    case (step_reg)
                        3'd0: fdp_reg <= fsat;
                        3'd1: fmp_reg <= fsat;
                        3'd2: fdn_reg <= fsat;
                        3'd3: fmn_reg <= fsat;
                        3'd4: hd_tmp_reg <= hd_calc;
                        default:
                        begin
                            // Last step: push the half-step cell.
                            hdw_reg[0] <= hdw_reg[1];
                            hdw_reg[1] <= hdw_reg[2];
                            hdw_reg[2] <= hd_tmp_reg;
                            hmw_reg[0] <= hmw_reg[1];
                            hmw_reg[1] <= hmw_reg[2];
                            hmw_reg[2] <= hm_calc;
                            hew_reg[0] <= hew_reg[1];
                            hew_reg[1] <= hew_reg[2];
                            hew_reg[2] <= err_calc;
                            job_reg    <= job_reg + 3'd1;
                        end
                    endcase
                end
                ST_EM_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_EM_OUT;
                end
                ST_EM_OUT:
                begin
                    // Wait until the output register is free.
                    if (out_load)
                    begin
                        out_reg.out_density   <= hdw_reg[em_cs];
                        out_reg.out_momentum  <= em_calc;
                        out_reg.cell_index    <= em_idx[IDX_W-1:0];
                        out_reg.out_last_cell <= em_last;
                        out_reg.density_error <= hew_reg[em_cs];
                        job_reg               <= job_reg + 3'd1;
                        state_reg             <= ST_DISPATCH;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
